// ===== rtl/can_frame_filter_csv_formatter_top_macros.svh =====
// Assertion macros for the checker of the CAN frame CSV formatter.
`ifndef CAN_FRAME_FILTER_CSV_FORMATTER_TOP_MACROS_SVH
`define CAN_FRAME_FILTER_CSV_FORMATTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define CFCSV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfcsv check failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define CFCSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfcsv check failed");

`endif

// ===== rtl/cfcsv_pkg.sv =====
// Types, constants and the control store of the CAN frame CSV formatter.
package cfcsv_pkg;

  localparam int ID_W      = 29;
  localparam int STD_ID_W  = 11;
  localparam int DLC_W     = 4;
  localparam int NUM_BYTES = 8;
  localparam int TICKS_W   = 32;
  localparam int DEC_DIGS  = 10;
  localparam int BCD_W     = 4 * DEC_DIGS;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 29;
  localparam int STEP_W    = 4;
  localparam int CNT_W     = 4;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOGGING_ENABLED = 3'd0,
    REG_LOG_STANDARD    = 3'd1,
    REG_LOG_EXTENDED    = 3'd2,
    REG_FILTER_MASK     = 3'd3,
    REG_FILTER_VALUE    = 3'd4,
    REG_TIMESTAMP_ON    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic            logging_enabled;
    logic            log_standard;
    logic            log_extended;
    logic [ID_W-1:0] filter_mask;
    logic [ID_W-1:0] filter_value;
    logic            timestamp_on;
  } cfg_t;

  typedef struct packed {
    logic                          is_extended;
    logic [ID_W-1:0]               identifier;
    logic [DLC_W-1:0]              byte_count;
    logic [NUM_BYTES-1:0][7:0]     data;
    logic [TICKS_W-1:0]            time_ticks;
  } frame_t;

  // Datapath actions
  typedef enum logic [3:0] {
    OP_LOAD, OP_NOP, OP_DABBLE, OP_DEC, OP_HEX,
    OP_COMMA, OP_HI, OP_LO, OP_CR, OP_LF
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEXT, C_ALWAYS, C_DROP, C_NO_TS, C_CNT_NOT15, C_CNT_NOT0, C_BYTES_DONE
  } cond_t;

  // Loop counter actions; LOOP forms step while jumping, else load cnt_val
  typedef enum logic [2:0] {
    CNT_KEEP, CNT_SET, CNT_INC, CNT_LOOP_INC, CNT_LOOP_DEC
  } cnt_op_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [STEP_W-1:0] target;
    cnt_op_t          cnt_op;
    logic [CNT_W-1:0] cnt_val;
  } cw_t;

  typedef struct packed {
    op_t              op;
    cnt_op_t          cnt_op;
    logic [CNT_W-1:0] cnt_val;
    logic             fire;
    logic             jump;
  } ctrl_t;

  typedef struct packed {
    logic drop;
    logic no_ts;
    logic cnt_not15;
    logic cnt_not0;
    logic bytes_done;
    logic out_space;
  } status_t;

  // Program step addresses
  localparam logic [STEP_W-1:0] ST_WAIT     = 4'd0;
  localparam logic [STEP_W-1:0] ST_FILTER   = 4'd1;
  localparam logic [STEP_W-1:0] ST_TS_CHK   = 4'd2;
  localparam logic [STEP_W-1:0] ST_DABBLE   = 4'd3;
  localparam logic [STEP_W-1:0] ST_DEC      = 4'd4;
  localparam logic [STEP_W-1:0] ST_TS_COMMA = 4'd5;
  localparam logic [STEP_W-1:0] ST_HEX_INIT = 4'd6;
  localparam logic [STEP_W-1:0] ST_HEX      = 4'd7;
  localparam logic [STEP_W-1:0] ST_BYTE_CHK = 4'd8;
  localparam logic [STEP_W-1:0] ST_B_COMMA  = 4'd9;
  localparam logic [STEP_W-1:0] ST_B_HI     = 4'd10;
  localparam logic [STEP_W-1:0] ST_B_LO     = 4'd11;
  localparam logic [STEP_W-1:0] ST_CR       = 4'd12;
  localparam logic [STEP_W-1:0] ST_LF       = 4'd13;

  localparam logic [CNT_W-1:0] DABBLE_LAST = 4'd15;
  localparam logic [CNT_W-1:0] DEC_TOP     = 4'(DEC_DIGS - 1);
  localparam logic [CNT_W-1:0] HEX_TOP     = 4'd7;
  localparam logic [CNT_W-1:0] CNT_ZERO    = 4'd0;

  function automatic cw_t mk(op_t op, cond_t cond, logic [STEP_W-1:0] target,
                             cnt_op_t cnt_op, logic [CNT_W-1:0] cnt_val);
    cw_t w;
    w.op      = op;
    w.cond    = cond;
    w.target  = target;
    w.cnt_op  = cnt_op;
    w.cnt_val = cnt_val;
    return w;
  endfunction

  // Control store: one control word per program step
  function automatic cw_t cw_rom(logic [STEP_W-1:0] pc);
    cw_t w;
    unique case (pc)
      ST_WAIT:     w = mk(OP_LOAD,   C_NEXT,       ST_WAIT,     CNT_SET,      CNT_ZERO);
      ST_FILTER:   w = mk(OP_NOP,    C_DROP,       ST_WAIT,     CNT_KEEP,     CNT_ZERO);
      ST_TS_CHK:   w = mk(OP_NOP,    C_NO_TS,      ST_HEX_INIT, CNT_SET,      CNT_ZERO);
      ST_DABBLE:   w = mk(OP_DABBLE, C_CNT_NOT15,  ST_DABBLE,   CNT_LOOP_INC, DEC_TOP);
      ST_DEC:      w = mk(OP_DEC,    C_CNT_NOT0,   ST_DEC,      CNT_LOOP_DEC, HEX_TOP);
      ST_TS_COMMA: w = mk(OP_COMMA,  C_ALWAYS,     ST_HEX,      CNT_KEEP,     CNT_ZERO);
      ST_HEX_INIT: w = mk(OP_NOP,    C_NEXT,       ST_WAIT,     CNT_SET,      HEX_TOP);
      ST_HEX:      w = mk(OP_HEX,    C_CNT_NOT0,   ST_HEX,      CNT_LOOP_DEC, CNT_ZERO);
      ST_BYTE_CHK: w = mk(OP_NOP,    C_BYTES_DONE, ST_CR,       CNT_KEEP,     CNT_ZERO);
      ST_B_COMMA:  w = mk(OP_COMMA,  C_NEXT,       ST_WAIT,     CNT_KEEP,     CNT_ZERO);
      ST_B_HI:     w = mk(OP_HI,     C_NEXT,       ST_WAIT,     CNT_KEEP,     CNT_ZERO);
      ST_B_LO:     w = mk(OP_LO,     C_ALWAYS,     ST_BYTE_CHK, CNT_INC,      CNT_ZERO);
      ST_CR:       w = mk(OP_CR,     C_NEXT,       ST_WAIT,     CNT_KEEP,     CNT_ZERO);
      ST_LF:       w = mk(OP_LF,     C_ALWAYS,     ST_WAIT,     CNT_KEEP,     CNT_ZERO);
      default:     w = mk(OP_NOP,    C_ALWAYS,     ST_WAIT,     CNT_KEEP,     CNT_ZERO);
    endcase
    return w;
  endfunction

  // Uppercase hex digit
  function automatic logic [7:0] hex_char(logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'h0: c = 8'h30;  4'h1: c = 8'h31;  4'h2: c = 8'h32;  4'h3: c = 8'h33;
      4'h4: c = 8'h34;  4'h5: c = 8'h35;  4'h6: c = 8'h36;  4'h7: c = 8'h37;
      4'h8: c = 8'h38;  4'h9: c = 8'h39;  4'hA: c = 8'h41;  4'hB: c = 8'h42;
      4'hC: c = 8'h43;  4'hD: c = 8'h44;  4'hE: c = 8'h45;  default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/cfcsv_ifs.sv =====
// Channel interfaces: frame input, text output and register write port.
interface cfcsv_frame_if;
  import cfcsv_pkg::*;
  logic                valid;
  logic                ready;
  logic                is_extended;
  logic [ID_W-1:0]     identifier;
  logic [DLC_W-1:0]    byte_count;
  logic [7:0]          data_byte0;
  logic [7:0]          data_byte1;
  logic [7:0]          data_byte2;
  logic [7:0]          data_byte3;
  logic [7:0]          data_byte4;
  logic [7:0]          data_byte5;
  logic [7:0]          data_byte6;
  logic [7:0]          data_byte7;
  logic [TICKS_W-1:0]  time_ticks;
  modport source (output valid, is_extended, identifier, byte_count, data_byte0,
                  data_byte1, data_byte2, data_byte3, data_byte4, data_byte5,
                  data_byte6, data_byte7, time_ticks, input ready);
  modport sink (input valid, is_extended, identifier, byte_count, data_byte0,
                data_byte1, data_byte2, data_byte3, data_byte4, data_byte5,
                data_byte6, data_byte7, time_ticks, output ready);
endinterface

interface cfcsv_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;
  modport source (output valid, text_byte, line_end, input ready);
  modport sink (input valid, text_byte, line_end, output ready);
endinterface

interface cfcsv_cfg_if;
  import cfcsv_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/can_frame_filter_csv_formatter_top.sv =====
// Top level of the CAN frame filter and CSV line formatter.
//
// frame (sink): one received CAN frame per word; ready is high only while the
//   block waits for a frame, so one frame is worked on at a time.
// text (source): one ASCII character per word; line_end marks the LF closing
//   a line. Dropped frames produce no words.
// cfg (sink): register writes, always ready; index selects the register,
//   unknown indexes are ignored. Write only while the block is idle.
// Steps: a dropped frame goes from the filter step back to the wait step. A
//   kept frame runs the wait, filter and timestamp check steps, then with the
//   timestamp on the binary-to-BCD conversion (2 bits per cycle), the 10
//   decimal digit positions and a comma, with it off a counter setup step
//   instead; then the 8 identifier hex digit positions, a comma and two hex
//   digits per data byte, and CR LF. Every digit position is visited, so the
//   running time does not depend on the values printed.
// Stalls: a full output register holds the sequencer on its emit step; no
//   character is lost or repeated.
// Reset: rst (synchronous) clears the step counter and output valid and loads
//   the register defaults (logging off, both frame kinds on, timestamp on).
module can_frame_filter_csv_formatter_top (
  input logic           clk,
  input logic           rst,
  cfcsv_frame_if.sink   frame,
  cfcsv_text_if.source  text,
  cfcsv_cfg_if.sink     cfg
);
  import cfcsv_pkg::*;

  cfg_t    cfg_regs;
  frame_t  frame_in;
  ctrl_t   ctrl;
  status_t status;

  // Register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.logging_enabled <= 1'b0;
      cfg_regs.log_standard    <= 1'b1;
      cfg_regs.log_extended    <= 1'b1;
      cfg_regs.filter_mask     <= '0;
      cfg_regs.filter_value    <= '0;
      cfg_regs.timestamp_on    <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LOGGING_ENABLED: cfg_regs.logging_enabled <= cfg.data[0];
        REG_LOG_STANDARD:    cfg_regs.log_standard    <= cfg.data[0];
        REG_LOG_EXTENDED:    cfg_regs.log_extended    <= cfg.data[0];
        REG_FILTER_MASK:     cfg_regs.filter_mask     <= cfg.data[ID_W-1:0];
        REG_FILTER_VALUE:    cfg_regs.filter_value    <= cfg.data[ID_W-1:0];
        REG_TIMESTAMP_ON:    cfg_regs.timestamp_on    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Frame fields into one bundle
  assign frame_in.is_extended = frame.is_extended;
  assign frame_in.identifier  = frame.identifier;
  assign frame_in.byte_count  = frame.byte_count;
  assign frame_in.data[0]     = frame.data_byte0;
  assign frame_in.data[1]     = frame.data_byte1;
  assign frame_in.data[2]     = frame.data_byte2;
  assign frame_in.data[3]     = frame.data_byte3;
  assign frame_in.data[4]     = frame.data_byte4;
  assign frame_in.data[5]     = frame.data_byte5;
  assign frame_in.data[6]     = frame.data_byte6;
  assign frame_in.data[7]     = frame.data_byte7;
  assign frame_in.time_ticks  = frame.time_ticks;

  cfcsv_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .status   (status),
    .in_ready (frame.ready),
    .ctrl     (ctrl)
  );

  cfcsv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .frame     (frame_in),
    .ctrl      (ctrl),
    .out_ready (text.ready),
    .status    (status),
    .out_valid (text.valid),
    .out_byte  (text.text_byte),
    .out_last  (text.line_end)
  );

endmodule

// ===== rtl/cfcsv_seq.sv =====
// Microcode sequencer: step counter, control store read and jump logic.
module cfcsv_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cfcsv_pkg::status_t status,
  output logic              in_ready,
  output cfcsv_pkg::ctrl_t  ctrl
);
  import cfcsv_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  cw_t               cw;
  logic              fire;
  logic              jump;

  assign cw = cw_rom(pc);

  // A step fires once its input or output side can move; internal steps always fire
  always_comb begin
    unique case (cw.op) inside
      OP_LOAD:           fire = in_valid;
      OP_NOP, OP_DABBLE: fire = 1'b1;
      default:           fire = status.out_space;
    endcase
  end

  // Jump condition decode
  always_comb begin
    unique case (cw.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_DROP:       jump = status.drop;
      C_NO_TS:      jump = status.no_ts;
      C_CNT_NOT15:  jump = status.cnt_not15;
      C_CNT_NOT0:   jump = status.cnt_not0;
      C_BYTES_DONE: jump = status.bytes_done;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (fire) begin
      pc_next = jump ? cw.target : pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign in_ready     = (cw.op == OP_LOAD);
  assign ctrl.op      = cw.op;
  assign ctrl.cnt_op  = cw.cnt_op;
  assign ctrl.cnt_val = cw.cnt_val;
  assign ctrl.fire    = fire;
  assign ctrl.jump    = jump;

endmodule

// ===== rtl/cfcsv_dp.sv =====
// Datapath: frame registers, BCD converter, loop counter and output word register.
module cfcsv_dp (
  input  logic              clk,
  input  logic              rst,
  input  cfcsv_pkg::cfg_t   cfg,
  input  cfcsv_pkg::frame_t frame,
  input  cfcsv_pkg::ctrl_t  ctrl,
  input  logic              out_ready,
  output cfcsv_pkg::status_t status,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import cfcsv_pkg::*;

  logic                      ext;
  logic [ID_W-1:0]           id_eff;
  logic [DLC_W-1:0]          cnt_sat;
  logic [NUM_BYTES-1:0][7:0] data;
  logic [TICKS_W-1:0]        tick_sr;
  logic [BCD_W-1:0]          bcd;
  logic [BCD_W-1:0]          bcd_next;
  logic [CNT_W-1:0]          cnt;
  logic                      started;
  logic [31:0]               id32;
  logic [3:0]                dec_digit;
  logic [3:0]                hex_digit;
  logic [7:0]                cur_byte;
  logic                      digit_op;
  logic                      emit_en;
  logic [7:0]                emit_char;
  logic                      out_space;

  // One double-dabble bit: adjust each digit, then shift in a bit
  function automatic logic [BCD_W-1:0] dabble(logic [BCD_W-1:0] v, logic b);
    logic [BCD_W-1:0] a;
    a = v;
    for (int i = 0; i < DEC_DIGS; i++) begin
      if (a[4*i +: 4] >= 4'd5) begin
        a[4*i +: 4] = a[4*i +: 4] + 4'd3;
      end
    end
    return {a[BCD_W-2:0], b};
  endfunction

  // Two ticks bits per cycle
  assign bcd_next = dabble(dabble(bcd, tick_sr[TICKS_W-1]), tick_sr[TICKS_W-2]);

  assign id32      = {{(32-ID_W){1'b0}}, id_eff};
  assign dec_digit = bcd[{cnt, 2'b00} +: 4];
  assign hex_digit = id32[{cnt[2:0], 2'b00} +: 4];
  assign cur_byte  = data[cnt[2:0]];
  assign digit_op  = (ctrl.op == OP_DEC) || (ctrl.op == OP_HEX);
  assign out_space = !out_valid || out_ready;

  // Character select; leading zero digits are skipped
  always_comb begin
    emit_en   = 1'b1;
    emit_char = CH_ZERO;
    case (ctrl.op)
      OP_DEC: begin
        emit_char = CH_ZERO + {4'd0, dec_digit};
        emit_en   = (dec_digit != 4'd0) || started || (cnt == CNT_ZERO);
      end
      OP_HEX: begin
        emit_char = hex_char(hex_digit);
        emit_en   = (hex_digit != 4'd0) || started || (cnt == CNT_ZERO);
      end
      OP_COMMA: emit_char = CH_COMMA;
      OP_HI:    emit_char = hex_char(cur_byte[7:4]);
      OP_LO:    emit_char = hex_char(cur_byte[3:0]);
      OP_CR:    emit_char = CH_CR;
      OP_LF:    emit_char = CH_LF;
      default:  emit_en   = 1'b0;
    endcase
  end

  // Frame capture and BCD conversion
  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.op == OP_LOAD) begin
      ext     <= frame.is_extended;
      id_eff  <= frame.is_extended ? frame.identifier
                                   : {{(ID_W-STD_ID_W){1'b0}}, frame.identifier[STD_ID_W-1:0]};
      cnt_sat <= (frame.byte_count > DLC_W'(NUM_BYTES)) ? DLC_W'(NUM_BYTES)
                                                         : frame.byte_count;
      data    <= frame.data;
      tick_sr <= frame.time_ticks;
      bcd     <= '0;
    end else if (ctrl.fire && ctrl.op == OP_DABBLE) begin
      bcd     <= bcd_next;
      tick_sr <= {tick_sr[TICKS_W-3:0], 2'b00};
    end
  end

  // Loop counter and leading-zero flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= CNT_ZERO;
      started <= 1'b0;
    end else if (ctrl.fire) begin
      started <= digit_op ? (started || emit_en) : 1'b0;
      case (ctrl.cnt_op)
        CNT_SET:      cnt <= ctrl.cnt_val;
        CNT_INC:      cnt <= cnt + 1'b1;
        CNT_LOOP_INC: cnt <= ctrl.jump ? cnt + 1'b1 : ctrl.cnt_val;
        CNT_LOOP_DEC: cnt <= ctrl.jump ? cnt - 1'b1 : ctrl.cnt_val;
        default:      cnt <= cnt;
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire && emit_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && emit_en) begin
      out_byte <= emit_char;
      out_last <= (ctrl.op == OP_LF);
    end
  end

  // Status back to the sequencer
  assign status.drop = !cfg.logging_enabled
                    || (ext ? !cfg.log_extended : !cfg.log_standard)
                    || (((id_eff ^ cfg.filter_value) & cfg.filter_mask) != '0);
  assign status.no_ts      = !cfg.timestamp_on;
  assign status.cnt_not15  = (cnt != DABBLE_LAST);
  assign status.cnt_not0   = (cnt != CNT_ZERO);
  assign status.bytes_done = (cnt == cnt_sat);
  assign status.out_space  = out_space;

endmodule

// ===== rtl/cfcsv_checker.sv =====
// Port-level checker for the CAN frame CSV formatter, bound to the top level.
`include "can_frame_filter_csv_formatter_top_macros.svh"

module cfcsv_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] text_byte,
  input logic       line_end
);
  import cfcsv_pkg::*;

  // A stalled word holds
  `CFCSV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(text_byte) && $stable(line_end))

  // After a frame is taken the input closes while it is worked on
  `CFCSV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // The line end word is LF
  `CFCSV_ASSERT_IMPL(a_end_is_lf, out_valid && line_end, text_byte == CH_LF)

  // LF appears only at the line end
  `CFCSV_ASSERT_IMPL(a_lf_is_end, out_valid && !line_end, text_byte != CH_LF)

endmodule

bind can_frame_filter_csv_formatter_top cfcsv_checker u_cfcsv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (frame.valid),
  .in_ready  (frame.ready),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .text_byte (text.text_byte),
  .line_end  (text.line_end)
);
